FILE: src/assert_macros.svh
// Assertion helpers. They expect a clock named clock and a synchronous
// reset named reset in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDCD_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JDCD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: src/jdcd_pkg.sv
`default_nettype none

package jdcd_pkg;

   localparam int IN_W                  = 39;
   localparam int YEAR_W                = 16;
   localparam int MONTH_W               = 4;
   localparam int DOM_W                 = 5;
   localparam int FRAC_W                = 16;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int SUM_W    = IN_W + 1;
   localparam int DAYNUM_W = 32;
   localparam int STAGES   = 13;

   // Reciprocal multiply for the two large constant divisions.
   localparam int XA_W    = DAYNUM_W + 2;
   localparam int XHI_W   = XA_W - 2;
   localparam int RECIP_W = 24;
   localparam int PROD_W  = XHI_W + RECIP_W;

   localparam logic [DAYNUM_W-1:0] GREG_START = 32'd2299161;

   localparam logic [XA_W-1:0]    ALPHA_BIAS  = 34'd7468865;
   localparam logic [RECIP_W-1:0] ALPHA_RECIP = 24'd15051802;
   localparam int                 ALPHA_SHIFT = 39;
   localparam int                 ALPHA_Q_W   = PROD_W - ALPHA_SHIFT;
   localparam int                 ALPHA_R_W   = 19;
   localparam logic [ALPHA_R_W-1:0] ALPHA_DIV = 19'd146097;

   localparam int                  BOFS_W      = 17;
   localparam logic [BOFS_W-1:0]   GREG_OFFSET = 17'd1525;
   localparam logic [BOFS_W-1:0]   JUL_OFFSET  = 17'd1524;
   localparam int                  KC_W        = BOFS_W + 2;
   localparam logic [KC_W-1:0]     CENT_BIAS   = 19'd489;

   localparam logic [RECIP_W-1:0]  CENT_RECIP = 24'd11758979;
   localparam int                  CENT_SHIFT = 32;
   localparam int                  CENT_Q_W   = PROD_W - CENT_SHIFT;
   localparam int                  CENT_R_W   = 13;
   localparam logic [CENT_R_W-1:0] CENT_DIV   = 13'd1461;
   localparam logic [CENT_R_W-1:0] CENT_DIV2  = 13'd2922;

   // B - D always stays below 2**LOW_W, so only low bits are carried.
   localparam int LOW_W = 10;
   localparam int DQ_W  = LOW_W + 2;

   localparam int                 E_W        = 6;
   localparam int                 MON_RCP_W  = 25;
   localparam logic [MON_RCP_W-1:0] MON_RECIP = 25'd17544744;
   localparam int                 MON_PROD_W = LOW_W + MON_RCP_W;
   localparam int                 MON_SHIFT  = MON_PROD_W - E_W;

   localparam int                 DAY_K_W     = 32;
   localparam logic [DAY_K_W-1:0] DAY_K       = 32'd2577409875;
   localparam int                 DAY_PROD_W  = E_W + DAY_K_W;
   localparam logic [LOW_W-1:0]   DAY_WHOLE   = 10'd30;

   localparam logic [E_W-1:0]     MONTH_WRAP_E = 6'd14;
   localparam logic [E_W-1:0]     MONTH_EARLY  = 6'd1;
   localparam logic [E_W-1:0]     MONTH_LATE   = 6'd13;
   localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
   localparam logic [YEAR_W-1:0]  YEAR_LATE    = 16'd4716;
   localparam logic [YEAR_W-1:0]  YEAR_EARLY   = 16'd4715;

   typedef struct packed {
      logic [STAGES-1:0] load;
      logic [STAGES-1:0] valid;
   } jdcd_flow_type;

endpackage

`default_nettype wire

FILE: src/jdcd_req_if.sv
`default_nettype none

interface jdcd_req_if;
   logic                        valid;
   logic                        ready;
   logic [jdcd_pkg::IN_W-1:0]   julian_day_fixed;

   modport source (output valid, output julian_day_fixed, input ready);
   modport sink (input valid, input julian_day_fixed, output ready);
endinterface

`default_nettype wire

FILE: src/jdcd_rsp_if.sv
`default_nettype none

interface jdcd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [jdcd_pkg::YEAR_W-1:0] year;
   logic [jdcd_pkg::MONTH_W-1:0]       month;
   logic [jdcd_pkg::DOM_W-1:0]         day_of_month;
   logic [jdcd_pkg::FRAC_W-1:0]        day_fraction;

   modport source (output valid, output year, output month, output day_of_month,
                   output day_fraction, input ready);
   modport sink (input valid, input year, input month, input day_of_month,
                 input day_fraction, output ready);
endinterface

`default_nettype wire

FILE: src/jdcd_flow_ctrl.sv
`default_nettype none

module jdcd_flow_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic                    out_ready,
   output logic                         in_ready,
   output jdcd_pkg::jdcd_flow_type      flow
);

   localparam int STG = jdcd_pkg::STAGES;

   logic [STG-1:0] valid_ff;
   logic [STG-1:0] valid_in;
   logic [STG-1:0] load;

   // A stage may load when some stage at or after it is empty, or the
   // consumer takes the oldest request.
   always_comb begin
      for (int i = 0; i < STG; i++) begin
         load[i] = out_ready | ~&(valid_ff | ((STG'(1) << i) - STG'(1)));
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < STG; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = load[0];
   assign flow.load  = load;
   assign flow.valid = valid_ff;

endmodule

`default_nettype wire

FILE: src/julian_day_to_calendar_date_core.sv
// Converts a Julian day in unsigned fixed point into year, month, day of
// month and a 16-bit day fraction, with the Gregorian correction from day
// 2299161 on and the Julian calendar before it. A request enters every
// cycle unless every stage is full and the result is not taken. The core
// uses two constant divisions done by reciprocal multiply, each followed
// by a remainder check and correction, and the month and day split after
// them. Each stage holds its request until the next one is free, so new
// requests are taken while a result waits as long as any stage is empty.
// There is no state between requests and no clearing pass after reset.
`default_nettype none
`include "assert_macros.svh"

module julian_day_to_calendar_date_core #(
   parameter int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   jdcd_req_if.sink  req_chan,
   jdcd_rsp_if.source rsp_chan
);

   localparam int SW   = jdcd_pkg::SUM_W;
   localparam int DW   = jdcd_pkg::DAYNUM_W;
   localparam int XW   = jdcd_pkg::XA_W;
   localparam int PW   = jdcd_pkg::PROD_W;
   localparam int FW   = jdcd_pkg::FRAC_W;
   localparam int AQW  = jdcd_pkg::ALPHA_Q_W;
   localparam int ARW  = jdcd_pkg::ALPHA_R_W;
   localparam int BW   = jdcd_pkg::BOFS_W;
   localparam int KW   = jdcd_pkg::KC_W;
   localparam int CQW  = jdcd_pkg::CENT_Q_W;
   localparam int CRW  = jdcd_pkg::CENT_R_W;
   localparam int LW   = jdcd_pkg::LOW_W;
   localparam int DQW  = jdcd_pkg::DQ_W;
   localparam int YW   = jdcd_pkg::YEAR_W;
   localparam int EW   = jdcd_pkg::E_W;
   localparam int MPW  = jdcd_pkg::MON_PROD_W;
   localparam int KPW  = jdcd_pkg::DAY_PROD_W;
   localparam int MW   = jdcd_pkg::MONTH_W;
   localparam int OW   = jdcd_pkg::DOM_W;
   localparam int STG  = jdcd_pkg::STAGES;

   localparam logic [SW-1:0] HALF_DAY = SW'(1) << (FRACTION_BITS - 1);

   jdcd_pkg::jdcd_flow_type flow;
   logic                    req_ready;

   jdcd_flow_ctrl u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .out_ready (rsp_chan.ready),
      .in_ready  (req_ready),
      .flow      (flow)
   );

   assign req_chan.ready = req_ready;

   // Stage 1: add half a day, split day number and fraction.
   logic [SW-1:0] s1_sum;
   logic [DW-1:0] s1_daynum_in, s1_daynum_ff;
   logic [FW-1:0] s1_frac_in, s1_frac_ff;

   assign s1_sum       = SW'(req_chan.julian_day_fixed) + HALF_DAY;
   assign s1_daynum_in = DW'(s1_sum >> FRACTION_BITS);

   generate
      if (FRACTION_BITS >= FW) begin : g_frac_trunc
         assign s1_frac_in = s1_sum[FRACTION_BITS-1 -: FW];
      end else begin : g_frac_pad
         assign s1_frac_in = {s1_sum[FRACTION_BITS-1:0], {(FW - FRACTION_BITS){1'b0}}};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (flow.load[0]) begin
         s1_daynum_ff <= s1_daynum_in;
         s1_frac_ff   <= s1_frac_in;
      end
   end

   // Stage 2: numerator of the century correction and calendar choice.
   logic [XW-1:0] s2_xa_in, s2_xa_ff;
   logic          s2_greg_in, s2_greg_ff;
   logic [DW-1:0] s2_daynum_ff;
   logic [FW-1:0] s2_frac_ff;

   assign s2_xa_in   = {s1_daynum_ff, 2'b00} - jdcd_pkg::ALPHA_BIAS;
   assign s2_greg_in = s1_daynum_ff >= jdcd_pkg::GREG_START;

   always_ff @(posedge clock) begin
      if (flow.load[1]) begin
         s2_xa_ff     <= s2_xa_in;
         s2_greg_ff   <= s2_greg_in;
         s2_daynum_ff <= s1_daynum_ff;
         s2_frac_ff   <= s1_frac_ff;
      end
   end

   // Stage 3: quotient estimate for alpha, low by at most one.
   logic [PW-1:0]  s3_prod;
   logic [AQW-1:0] s3_qa_in, s3_qa_ff;
   logic [ARW-1:0] s3_xlo_ff;
   logic           s3_greg_ff;
   logic [DW-1:0]  s3_daynum_ff;
   logic [FW-1:0]  s3_frac_ff;

   assign s3_prod  = PW'(s2_xa_ff[XW-1:2]) * PW'(jdcd_pkg::ALPHA_RECIP);
   assign s3_qa_in = s3_prod[PW-1:jdcd_pkg::ALPHA_SHIFT];

   always_ff @(posedge clock) begin
      if (flow.load[2]) begin
         s3_qa_ff     <= s3_qa_in;
         s3_xlo_ff    <= s2_xa_ff[ARW-1:0];
         s3_greg_ff   <= s2_greg_ff;
         s3_daynum_ff <= s2_daynum_ff;
         s3_frac_ff   <= s2_frac_ff;
      end
   end

   // Stage 4: remainder of the estimate; it fits in the low bits.
   logic [ARW-1:0] s4_ra_in, s4_ra_ff;
   logic [AQW-1:0] s4_qa_ff;
   logic           s4_greg_ff;
   logic [DW-1:0]  s4_daynum_ff;
   logic [FW-1:0]  s4_frac_ff;

   assign s4_ra_in = s3_xlo_ff - ARW'(ARW'(s3_qa_ff) * jdcd_pkg::ALPHA_DIV);

   always_ff @(posedge clock) begin
      if (flow.load[3]) begin
         s4_ra_ff     <= s4_ra_in;
         s4_qa_ff     <= s3_qa_ff;
         s4_greg_ff   <= s3_greg_ff;
         s4_daynum_ff <= s3_daynum_ff;
         s4_frac_ff   <= s3_frac_ff;
      end
   end

   // Stage 5: corrected alpha.
   logic [AQW-1:0] s5_alpha_in, s5_alpha_ff;
   logic           s5_greg_ff;
   logic [DW-1:0]  s5_daynum_ff;
   logic [FW-1:0]  s5_frac_ff;

   assign s5_alpha_in = s4_qa_ff + AQW'(s4_ra_ff >= jdcd_pkg::ALPHA_DIV);

   always_ff @(posedge clock) begin
      if (flow.load[4]) begin
         s5_alpha_ff  <= s5_alpha_in;
         s5_greg_ff   <= s4_greg_ff;
         s5_daynum_ff <= s4_daynum_ff;
         s5_frac_ff   <= s4_frac_ff;
      end
   end

   // Stage 6: offset from the day number to B.
   logic [BW-1:0] s6_bofs_in, s6_bofs_ff;
   logic [DW-1:0] s6_daynum_ff;
   logic [FW-1:0] s6_frac_ff;

   assign s6_bofs_in = s5_greg_ff
                     ? jdcd_pkg::GREG_OFFSET + BW'(s5_alpha_ff) - BW'(s5_alpha_ff >> 2)
                     : jdcd_pkg::JUL_OFFSET;

   always_ff @(posedge clock) begin
      if (flow.load[5]) begin
         s6_bofs_ff   <= s6_bofs_in;
         s6_daynum_ff <= s5_daynum_ff;
         s6_frac_ff   <= s5_frac_ff;
      end
   end

   // Stage 7: century numerator 4B - 489 and the low bits of B.
   logic [KW-1:0] s7_kc;
   logic [XW-1:0] s7_xc_in, s7_xc_ff;
   logic [LW-1:0] s7_blo_in, s7_blo_ff;
   logic [FW-1:0] s7_frac_ff;

   assign s7_kc     = {s6_bofs_ff, 2'b00} - jdcd_pkg::CENT_BIAS;
   assign s7_xc_in  = {s6_daynum_ff, 2'b00} + XW'(s7_kc);
   assign s7_blo_in = s6_daynum_ff[LW-1:0] + s6_bofs_ff[LW-1:0];

   always_ff @(posedge clock) begin
      if (flow.load[6]) begin
         s7_xc_ff   <= s7_xc_in;
         s7_blo_ff  <= s7_blo_in;
         s7_frac_ff <= s6_frac_ff;
      end
   end

   // Stage 8: quotient estimate for C, low by at most two.
   logic [PW-1:0]  s8_prod;
   logic [CQW-1:0] s8_qc_in, s8_qc_ff;
   logic [CRW-1:0] s8_xlo_ff;
   logic [LW-1:0]  s8_blo_ff;
   logic [FW-1:0]  s8_frac_ff;

   assign s8_prod  = PW'(s7_xc_ff[XW-1:2]) * PW'(jdcd_pkg::CENT_RECIP);
   assign s8_qc_in = s8_prod[PW-1:jdcd_pkg::CENT_SHIFT];

   always_ff @(posedge clock) begin
      if (flow.load[7]) begin
         s8_qc_ff   <= s8_qc_in;
         s8_xlo_ff  <= s7_xc_ff[CRW-1:0];
         s8_blo_ff  <= s7_blo_ff;
         s8_frac_ff <= s7_frac_ff;
      end
   end

   // Stage 9: remainder of the C estimate.
   logic [CRW-1:0] s9_rc_in, s9_rc_ff;
   logic [CQW-1:0] s9_qc_ff;
   logic [LW-1:0]  s9_blo_ff;
   logic [FW-1:0]  s9_frac_ff;

   assign s9_rc_in = s8_xlo_ff - CRW'(s8_qc_ff[CRW-1:0] * jdcd_pkg::CENT_DIV);

   always_ff @(posedge clock) begin
      if (flow.load[8]) begin
         s9_rc_ff   <= s9_rc_in;
         s9_qc_ff   <= s8_qc_ff;
         s9_blo_ff  <= s8_blo_ff;
         s9_frac_ff <= s8_frac_ff;
      end
   end

   // Stage 10: corrected C.
   logic [CQW-1:0] s10_c_in, s10_c_ff;
   logic [LW-1:0]  s10_blo_ff;
   logic [FW-1:0]  s10_frac_ff;

   always_comb begin
      if (s9_rc_ff >= jdcd_pkg::CENT_DIV2) begin
         s10_c_in = s9_qc_ff + CQW'(2);
      end else if (s9_rc_ff >= jdcd_pkg::CENT_DIV) begin
         s10_c_in = s9_qc_ff + CQW'(1);
      end else begin
         s10_c_in = s9_qc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.load[9]) begin
         s10_c_ff    <= s10_c_in;
         s10_blo_ff  <= s9_blo_ff;
         s10_frac_ff <= s9_frac_ff;
      end
   end

   // Stage 11: B - D from the low bits of B and of 1461 C / 4.
   logic [DQW-1:0] s11_dm;
   logic [LW-1:0]  s11_bd_in, s11_bd_ff;
   logic [YW-1:0]  s11_cent_ff;
   logic [FW-1:0]  s11_frac_ff;

   assign s11_dm    = DQW'(s10_c_ff[DQW-1:0] * DQW'(jdcd_pkg::CENT_DIV));
   assign s11_bd_in = s10_blo_ff - s11_dm[DQW-1:2];

   always_ff @(posedge clock) begin
      if (flow.load[10]) begin
         s11_bd_ff   <= s11_bd_in;
         s11_cent_ff <= s10_c_ff[YW-1:0];
         s11_frac_ff <= s10_frac_ff;
      end
   end

   // Stage 12: E = floor(10000 (B - D) / 306001).
   logic [MPW-1:0] s12_prod;
   logic [EW-1:0]  s12_e_in, s12_e_ff;
   logic [LW-1:0]  s12_bd_ff;
   logic [YW-1:0]  s12_cent_ff;
   logic [FW-1:0]  s12_frac_ff;

   assign s12_prod = MPW'(s11_bd_ff) * MPW'(jdcd_pkg::MON_RECIP);
   assign s12_e_in = s12_prod[MPW-1:jdcd_pkg::MON_SHIFT];

   always_ff @(posedge clock) begin
      if (flow.load[11]) begin
         s12_e_ff    <= s12_e_in;
         s12_bd_ff   <= s11_bd_ff;
         s12_cent_ff <= s11_cent_ff;
         s12_frac_ff <= s11_frac_ff;
      end
   end

   // Stage 13: day, month and year into the output register.
   logic [KPW-1:0] s13_prod;
   logic [LW-1:0]  s13_dsub;
   logic [LW-1:0]  s13_day;
   logic [EW-1:0]  s13_mon;
   logic [MW-1:0]  s13_month_in, s13_month_ff;
   logic [OW-1:0]  s13_dom_in, s13_dom_ff;
   logic [YW-1:0]  s13_year_in, s13_year_ff;
   logic [FW-1:0]  s13_frac_ff;

   assign s13_prod     = KPW'(s12_e_ff) * KPW'(jdcd_pkg::DAY_K);
   assign s13_dsub     = LW'(s12_e_ff) * jdcd_pkg::DAY_WHOLE
                       + LW'(s13_prod[KPW-1:jdcd_pkg::DAY_K_W]);
   assign s13_day      = s12_bd_ff - s13_dsub;
   assign s13_dom_in   = s13_day[OW-1:0];
   assign s13_mon      = (s12_e_ff < jdcd_pkg::MONTH_WRAP_E)
                       ? s12_e_ff - jdcd_pkg::MONTH_EARLY
                       : s12_e_ff - jdcd_pkg::MONTH_LATE;
   assign s13_month_in = s13_mon[MW-1:0];
   assign s13_year_in  = (s13_month_in > jdcd_pkg::FEBRUARY)
                       ? s12_cent_ff - jdcd_pkg::YEAR_LATE
                       : s12_cent_ff - jdcd_pkg::YEAR_EARLY;

   always_ff @(posedge clock) begin
      if (flow.load[12]) begin
         s13_year_ff  <= s13_year_in;
         s13_month_ff <= s13_month_in;
         s13_dom_ff   <= s13_dom_in;
         s13_frac_ff  <= s12_frac_ff;
      end
   end

   assign rsp_chan.valid        = flow.valid[STG-1];
   assign rsp_chan.year         = s13_year_ff;
   assign rsp_chan.month        = s13_month_ff;
   assign rsp_chan.day_of_month = s13_dom_ff;
   assign rsp_chan.day_fraction = s13_frac_ff;

   `JDCD_ASSERT_SAME(stall_only_when_full_a, !req_chan.ready, (&flow.valid) && !rsp_chan.ready, "request refused while a stage is free")
   `JDCD_ASSERT_NEXT(accept_fills_first_a, req_chan.valid && req_chan.ready, flow.valid[0], "accepted request not captured")
   `JDCD_ASSERT_NEXT(drain_empties_out_a, rsp_chan.valid && rsp_chan.ready && !flow.valid[STG-2], !rsp_chan.valid, "result repeated after it was taken")
   `JDCD_ASSERT_SAME(month_range_a, rsp_chan.valid, rsp_chan.month != 4'd0 && rsp_chan.month <= 4'd12, "month outside January to December")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
module testbench;

   localparam int IN_W          = jdcd_pkg::IN_W;
   localparam int YEAR_W        = jdcd_pkg::YEAR_W;
   localparam int MONTH_W       = jdcd_pkg::MONTH_W;
   localparam int DOM_W         = jdcd_pkg::DOM_W;
   localparam int FRAC_W        = jdcd_pkg::FRAC_W;
   localparam int FRACTION_BITS = jdcd_pkg::FRACTION_BITS_DEFAULT;
   localparam int ITEM_COUNT    = 1250;
   localparam int MAX_WAIT      = 6;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 2 * jdcd_pkg::STAGES;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   day_of_month;
      logic [FRAC_W-1:0]  day_fraction;
   } calendar_date_type;

   class date_scoreboard;
      calendar_date_type expected_dates[$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
      endfunction

      static function calendar_date_type julian_to_date(logic [IN_W-1:0] jd);
         bit [63:0] t, z, f, a, b, c, d, e, alpha, month_num;
         calendar_date_type r;
         t = 64'(jd) + (64'd1 << (FRACTION_BITS - 1));
         z = t >> FRACTION_BITS;
         f = t & ((64'd1 << FRACTION_BITS) - 64'd1);
         if (z < 64'(jdcd_pkg::GREG_START)) begin
            a = z;
         end else begin
            alpha = (64'd4 * z - 64'd7468865) / 64'd146097;
            a = z + 64'd1 + alpha - alpha / 64'd4;
         end
         b = a + 64'd1524;
         c = (64'd100 * b - 64'd12210) / 64'd36525;
         d = (64'd1461 * c) / 64'd4;
         e = (64'd10000 * (b - d)) / 64'd306001;
         r.day_of_month = DOM_W'(b - d - (64'd306001 * e) / 64'd10000);
         month_num = (e < 64'd14) ? e - 64'd1 : e - 64'd13;
         r.month = MONTH_W'(month_num);
         r.year = YEAR_W'((month_num > 64'd2) ? c - 64'd4716 : c - 64'd4715);
         if (FRACTION_BITS >= 16) begin
            r.day_fraction = FRAC_W'(f >> (FRACTION_BITS - 16));
         end else begin
            r.day_fraction = FRAC_W'(f << (16 - FRACTION_BITS));
         end
         return r;
      endfunction

      function void note_request(logic [IN_W-1:0] jd);
         expected_dates.push_back(julian_to_date(jd));
      endfunction

      function void check_result(calendar_date_type got);
         calendar_date_type want;
         if (expected_dates.size() == 0) begin
            $error("result with no request pending: year %0d month %0d day %0d",
                   $signed(got.year), got.month, got.day_of_month);
            mismatches++;
            return;
         end
         want = expected_dates.pop_front();
         if (got.year !== want.year) begin
            $error("year: expected %0d, got %0d", $signed(want.year), $signed(got.year));
            mismatches++;
         end
         if (got.month !== want.month) begin
            $error("month: expected %0d, got %0d", want.month, got.month);
            mismatches++;
         end
         if (got.day_of_month !== want.day_of_month) begin
            $error("day_of_month: expected %0d, got %0d", want.day_of_month,
                   got.day_of_month);
            mismatches++;
         end
         if (got.day_fraction !== want.day_fraction) begin
            $error("day_fraction: expected %0d, got %0d", want.day_fraction,
                   got.day_fraction);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   sender_bursting;
   bit   receiver_bursting;
   int   idle_cycles;

   date_scoreboard sb = new();

   jdcd_req_if req_chan();
   jdcd_rsp_if rsp_chan();

   julian_day_to_calendar_date_core #(
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #4 clock = ~clock;

   function automatic logic [IN_W-1:0] day_at(bit [63:0] z, bit [63:0] f);
      return IN_W'((z << FRACTION_BITS) + f - (64'd1 << (FRACTION_BITS - 1)));
   endfunction

   function automatic logic [IN_W-1:0] random_julian_day();
      bit [63:0] frac;
      frac = 64'($urandom()) & ((64'd1 << FRACTION_BITS) - 64'd1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return IN_W'({$urandom(), $urandom()});
         4, 5, 6, 7: return day_at($urandom_range(1, 2600000), frac);
         8: return day_at(64'(jdcd_pkg::GREG_START) + $urandom_range(0, 80) - 64'd40, frac);
         default: begin
            return day_at($urandom_range(8388000, 8388607),
                          frac & ((64'd1 << (FRACTION_BITS - 1)) - 64'd1));
         end
      endcase
   endfunction

   task automatic send_request(input logic [IN_W-1:0] jd);
      int gap;
      gap = sender_bursting ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.julian_day_fixed <= jd;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_request(req_chan.julian_day_fixed);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_result({rsp_chan.year, rsp_chan.month, rsp_chan.day_of_month,
                             rsp_chan.day_fraction});
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int stall;
      int results;
      rsp_chan.ready = 1'b0;
      receiver_bursting = 1'b0;
      results = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results % 100 == 0) begin
            receiver_bursting = ($urandom_range(0, 3) == 0);
         end
         stall = receiver_bursting ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         results++;
      end
   end

   initial begin
      logic [IN_W-1:0] directed_days[$];
      int n;
      clock = 1'b0;
      reset = 1'b1;
      sender_bursting = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.julian_day_fixed = '0;

      // Field extremes, the half-day rollover, both sides of the Gregorian
      // switch, leap and century years, and year boundaries.
      directed_days.push_back('0);
      directed_days.push_back('1);
      directed_days.push_back(IN_W'(64'd1 << (FRACTION_BITS - 1)) - 1'b1);
      directed_days.push_back(IN_W'(64'd1 << (FRACTION_BITS - 1)));
      directed_days.push_back(day_at(1, 0));
      directed_days.push_back(day_at(64'(jdcd_pkg::GREG_START) - 1,
                                     (64'd1 << FRACTION_BITS) - 1));
      directed_days.push_back(day_at(64'(jdcd_pkg::GREG_START), 0));
      directed_days.push_back(day_at(64'(jdcd_pkg::GREG_START) + 1, 12345));
      directed_days.push_back(day_at(1721058, 0));
      directed_days.push_back(day_at(1721424, 100));
      directed_days.push_back(day_at(2415079, 0));
      directed_days.push_back(day_at(2415080, 0));
      directed_days.push_back(day_at(2451545, 64'd1 << (FRACTION_BITS - 1)));
      directed_days.push_back(day_at(2451604, 0));
      directed_days.push_back(day_at(2451605, 0));
      directed_days.push_back(day_at(2451910, (64'd1 << FRACTION_BITS) - 1));
      directed_days.push_back(day_at(2451911, 1));
      directed_days.push_back(day_at(2400000, 54321));
      directed_days.push_back(day_at(8388607, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_days[i]) begin
         send_request(directed_days[i]);
      end
      for (n = directed_days.size(); n < ITEM_COUNT; n++) begin
         if (n % 100 == 0) begin
            sender_bursting = ($urandom_range(0, 3) == 0);
         end
         send_request(random_julian_day());
      end
      req_chan.valid <= 1'b0;

      while (sb.expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
